/* src/qtsg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the queued tone sine generator.
// Holds the quarter-wave sine entry function used to build the table ROM.
package qtsg_pkg;

  localparam int QUEUE_DEPTH_DEF     = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int MAX_BURST_DEF       = 64;

  localparam int AMP_W    = 15;
  localparam int RATE_W   = 18;
  localparam int INC_W    = 32;
  localparam int MS_W     = 16;
  localparam int CNT_W    = 7;
  localparam int LEN_W    = 24;
  localparam int PROD_W   = MS_W + RATE_W;
  localparam int SAMPLE_W = 16;
  localparam int QCNT_W   = 5;
  localparam int MAG_W    = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = RATE_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE = 1'd1;

  localparam logic CMD_NOTE = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd8000;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

  localparam int MS_PER_S = 1000;
  localparam int REM_W    = 10;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef struct packed {
    logic              command;
    logic [INC_W-1:0]  phase_increment;
    logic [MS_W-1:0]   duration_ms;
    logic [CNT_W-1:0]  sample_count;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       accepted;
    logic [QCNT_W-1:0]          queue_count;
  } out_word_t;

  typedef struct packed {
    logic [INC_W-1:0] inc;
    logic [LEN_W-1:0] len;
  } note_t;

  localparam int NOTE_W = $bits(note_t);

  function automatic logic [MAG_W-1:0] sine_q15(input int unsigned k, input int unsigned tb);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    x    = (PI_HALF_Q30 * longint'(k)) >> tb;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return MAG_W'(r);
  endfunction

endpackage

/* src/qtsg_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qtsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/qtsg_sine_rom.sv */
`timescale 1ns / 1ps
// Quarter-wave sine ROM, 2^TABLE_BITS + 1 entries, registered read.
// Depends on qtsg_pkg for the entry function.
module qtsg_sine_rom #(
  parameter int TABLE_BITS = qtsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic [TABLE_BITS:0]          addr,
  output logic [qtsg_pkg::MAG_W-1:0]   mag
);
  import qtsg_pkg::*;

  localparam int QTR_N = 1 << TABLE_BITS;

  typedef logic [MAG_W-1:0] tab_t [0:QTR_N];

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k <= QTR_N; k++) begin
      t[k] = sine_q15(k, TABLE_BITS);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [MAG_W-1:0] mag_r;

  always_ff @(posedge clk) begin
    mag_r <= SINE_TAB[addr];
  end

  assign mag = mag_r;

endmodule

/* src/qtsg_len_div.sv */
`timescale 1ns / 1ps
// Note length unit: duration_ms * sample_rate, then divide by 1000 as a shift by 3
// and a reciprocal multiply for 125, with the product and the quotient registered
// in turn, saturated to the note length width. Uses qtsg_pkg.
module qtsg_len_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qtsg_pkg::MS_W-1:0]     duration_ms,
  input  logic [qtsg_pkg::RATE_W-1:0]   sample_rate,
  output logic                          done,
  output logic [qtsg_pkg::LEN_W-1:0]    len
);
  import qtsg_pkg::*;

  localparam int PRE_SH = 3;
  localparam int P8_W   = PROD_W - PRE_SH;
  localparam int RCP_W  = 32;
  localparam int RCP_SH = 38;
  localparam int MUL_W  = P8_W + RCP_W;
  localparam int Q_W    = MUL_W - RCP_SH;

  localparam logic [RCP_W-1:0] RCP_125 = 32'd2199023256;

  logic              prod_vld_r, prod_vld_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [Q_W-1:0]    quot_r, quot_nxt;
  logic [MUL_W-1:0]  mul;

  always_comb begin
    prod_nxt     = prod_r;
    quot_nxt     = quot_r;
    prod_vld_nxt = 1'b0;
    done_nxt     = 1'b0;
    mul          = MUL_W'(prod_r[PROD_W-1:PRE_SH]) * MUL_W'(RCP_125);
    if (start) begin
      prod_nxt     = PROD_W'(duration_ms) * PROD_W'(sample_rate);
      prod_vld_nxt = 1'b1;
    end else if (prod_vld_r) begin
      quot_nxt = mul[MUL_W-1:RCP_SH];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      prod_vld_r <= prod_vld_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign len  = (quot_r[Q_W-1:LEN_W] != '0) ? {LEN_W{1'b1}} : quot_r[LEN_W-1:0];

endmodule

/* src/queued_tone_sine_generator.sv */
`timescale 1ns / 1ps
// Queued tone sine generator: a note queue driving a phase-accumulator sine source.
// Depends on qtsg_pkg, qtsg_ram, qtsg_sine_rom and qtsg_len_div.
//
// Usage:
//   Input words (in_valid/in_stall) are either note commands or generate commands.
//   A note command converts duration_ms to samples with a two-stage multiply and
//   reciprocal-divide unit and returns one word with accepted and queue_count;
//   S_NOTE waits for the unit, then S_NOTE_OUT puts that word in the output register.
//   A generate command returns min(sample_count, MAX_BURST) words; a count of zero
//   returns nothing. Each sample passes through S_FETCH (phase to table ROM) and
//   S_EMIT (scale), plus S_LOAD whenever a new queued note is fetched from the note RAM.
//   The block takes one command at a time: in_stall is high from acceptance until
//   the last word of that command sits in the output register, and the next
//   command can be taken while that word is there.
//   Output words are held in a single output register; while out_stall is high
//   a valid word holds and the sequencer waits.
//   Configuration writes (cfg_valid/cfg_ready) are always taken; cfg_ready is tied
//   high. Index 0 is amplitude, index 1 is sample_rate.
//   Reset clears the queue, the phase and the output valid, and restores the
//   configuration defaults. The note RAM is not cleared; only written entries
//   are read.
module queued_tone_sine_generator #(
  parameter int QUEUE_DEPTH     = qtsg_pkg::QUEUE_DEPTH_DEF,
  parameter int SINE_TABLE_BITS = qtsg_pkg::SINE_TABLE_BITS_DEF,
  parameter int MAX_BURST       = qtsg_pkg::MAX_BURST_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  qtsg_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output qtsg_pkg::out_word_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qtsg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [qtsg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qtsg_pkg::*;

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int BW    = $clog2(MAX_BURST + 1);
  localparam int TB    = SINE_TABLE_BITS;
  localparam int QTR_N = 1 << SINE_TABLE_BITS;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_NOTE     = 3'd1;
  localparam logic [2:0] S_NOTE_OUT = 3'd2;
  localparam logic [2:0] S_FETCH    = 3'd3;
  localparam logic [2:0] S_LOAD     = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [AMP_W-1:0] amp_r;
  logic [RATE_W-1:0] rate_r;
  logic [INC_W-1:0] phase_r, phase_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic [INC_W-1:0] cur_inc_r, cur_inc_nxt;
  logic [LEN_W-1:0] cur_left_r, cur_left_nxt;
  logic [BW-1:0]    burst_r, burst_nxt;
  logic [INC_W-1:0] note_inc_r, note_inc_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             out_free;
  logic             queue_full;
  logic [BW-1:0]    burst_load;
  logic             div_start;
  logic             div_done;
  logic [LEN_W-1:0] div_len;
  logic             ram_we;
  note_t            ram_wdata;
  note_t            ram_rdata;
  logic [TB:0]      rom_addr;
  logic [MAG_W-1:0] rom_mag;
  logic [AMP_W+MAG_W-1:0] scaled;
  logic [SAMPLE_W-1:0]    mag_amp;
  logic [AW-1:0]    head_inc;
  logic [AW-1:0]    tail_inc;
  logic [CW-1:0]    count_after;

  qtsg_len_div u_len_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .duration_ms (in_data.duration_ms),
    .sample_rate (rate_r),
    .done        (div_done),
    .len         (div_len)
  );

  qtsg_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_note_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (ram_wdata),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );

  qtsg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .mag  (rom_mag)
  );

  assign rom_addr = phase_r[INC_W-2] ? ((TB+1)'(QTR_N) - {1'b0, phase_r[INC_W-3 -: TB]})
                                     : {1'b0, phase_r[INC_W-3 -: TB]};
  assign scaled   = (AMP_W+MAG_W)'(amp_r) * (AMP_W+MAG_W)'(rom_mag);
  assign mag_amp  = scaled[AMP_W+MAG_W-1 -: SAMPLE_W];

  assign out_free   = !out_valid_r || !out_stall;
  assign queue_full = (count_r == CW'(QUEUE_DEPTH));
  assign burst_load = (in_data.sample_count > CNT_W'(MAX_BURST)) ? BW'(MAX_BURST)
                                                                  : BW'(in_data.sample_count);
  assign head_inc   = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign ram_wdata  = '{inc: note_inc_r, len: div_len};

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    cur_vld_nxt   = cur_vld_r;
    cur_inc_nxt   = cur_inc_r;
    cur_left_nxt  = cur_left_r;
    burst_nxt     = burst_r;
    note_inc_nxt  = note_inc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    count_after   = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == CMD_NOTE) begin
            div_start    = 1'b1;
            note_inc_nxt = in_data.phase_increment;
            state_nxt    = S_NOTE;
          end else if (burst_load != '0) begin
            burst_nxt = burst_load;
            state_nxt = S_FETCH;
          end
        end
      end
      S_NOTE: begin
        if (div_done) begin
          state_nxt = S_NOTE_OUT;
        end
      end
      S_NOTE_OUT: begin
        if (out_free) begin
          if (div_len != '0 && !queue_full) begin
            ram_we      = 1'b1;
            tail_nxt    = tail_inc;
            count_after = count_r + 1'b1;
          end
          count_nxt                 = count_after;
          out_valid_nxt             = 1'b1;
          out_word_nxt.sample       = '0;
          out_word_nxt.last         = 1'b1;
          out_word_nxt.accepted     = (div_len == '0) || !queue_full;
          out_word_nxt.queue_count  = QCNT_W'(count_after);
          state_nxt                 = S_IDLE;
        end
      end
      S_FETCH: begin
        state_nxt = (count_r != '0 && !cur_vld_r) ? S_LOAD : S_EMIT;
      end
      S_LOAD: begin
        cur_inc_nxt  = ram_rdata.inc;
        cur_left_nxt = ram_rdata.len;
        cur_vld_nxt  = 1'b1;
        state_nxt    = S_FETCH;
      end
      S_EMIT: begin
        if (out_free) begin
          out_word_nxt.sample = '0;
          if (count_r != '0) begin
            out_word_nxt.sample = phase_r[INC_W-1] ? -mag_amp : mag_amp;
            phase_nxt    = phase_r + cur_inc_r;
            cur_left_nxt = cur_left_r - 1'b1;
            if (cur_left_r == LEN_W'(1)) begin
              head_nxt    = head_inc;
              count_after = count_r - 1'b1;
              cur_vld_nxt = 1'b0;
            end
          end
          count_nxt                = count_after;
          out_valid_nxt            = 1'b1;
          out_word_nxt.last        = (burst_r == BW'(1));
          out_word_nxt.accepted    = 1'b0;
          out_word_nxt.queue_count = QCNT_W'(count_after);
          burst_nxt                = burst_r - 1'b1;
          state_nxt                = (burst_r == BW'(1)) ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      amp_r       <= AMP_RESET;
      rate_r      <= RATE_RESET;
      phase_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cur_vld_r   <= 1'b0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      cur_vld_r   <= cur_vld_nxt;
      burst_r     <= burst_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_AMPLITUDE:   amp_r  <= cfg_data[AMP_W-1:0];
          CFG_SAMPLE_RATE: rate_r <= cfg_data[RATE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_inc_r  <= cur_inc_nxt;
    cur_left_r <= cur_left_nxt;
    note_inc_r <= note_inc_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign cfg_ready = 1'b1;

  logic [AW:0] tail_chk;
  assign tail_chk = ((AW+1)'(head_r) + (AW+1)'(count_r) >= (AW+1)'(QUEUE_DEPTH))
                  ? (AW+1)'(head_r) + (AW+1)'(count_r) - (AW+1)'(QUEUE_DEPTH)
                  : (AW+1)'(head_r) + (AW+1)'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("note count above queue depth");

  a_cache_has_note: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> count_r != '0)
    else $error("cached head note with empty queue");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    tail_chk == (AW+1)'(tail_r))
    else $error("head, tail and count disagree");

  a_burst_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH || state_r == S_LOAD || state_r == S_EMIT) |-> burst_r != '0)
    else $error("sample sequencer running with empty burst");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT || $past(state_r) == S_NOTE_OUT))
    else $error("output word loaded outside an emit state");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for queued_tone_sine_generator: directed and random note and burst words,
// checked against a scoreboard that predicts every sample. Depends on qtsg_pkg.
module tb;
  import qtsg_pkg::*;

  localparam int              TBL_N   = 1 << SINE_TABLE_BITS_DEF;
  localparam longint unsigned LEN_MAX = (64'd1 << LEN_W) - 1;
  localparam int unsigned     LIMIT   = 2_000_000;

  class tone_scoreboard;
    logic [AMP_W-1:0]  amp;
    logic [RATE_W-1:0] rate;
    logic [INC_W-1:0]  note_inc [QUEUE_DEPTH_DEF];
    logic [LEN_W-1:0]  note_left [QUEUE_DEPTH_DEF];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       queued;
    logic [INC_W-1:0]  phase;
    logic [MAG_W-1:0]  quarter_wave [TBL_N+1];
    out_word_t         expected_words [$];
    int unsigned       errors;

    function new();
      longint unsigned x;
      longint unsigned term;
      longint unsigned acc;
      amp    = AMP_RESET;
      rate   = RATE_RESET;
      head   = 0;
      tail   = 0;
      queued = 0;
      phase  = '0;
      errors = 0;
      for (int k = 0; k <= TBL_N; k++) begin
        x    = (PI_HALF_Q30 * longint'(k)) >> SINE_TABLE_BITS_DEF;
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++) begin
          term = (((term * x) >> 30) * x) >> 30;
          term = term / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
          end else begin
            acc = acc + term;
          end
        end
        acc = (acc + 64'd16384) >> 15;
        if (acc > 64'd32768) begin
          acc = 64'd32768;
        end
        quarter_wave[k] = acc[MAG_W-1:0];
      end
    endfunction

    function logic [SAMPLE_W-1:0] tone_value(input logic [INC_W-1:0] ph);
      logic [1:0]       quad;
      int unsigned      k;
      logic [MAG_W-1:0] mag;
      logic [31:0]      v;
      quad = ph[31:30];
      k    = 32'(ph[29 -: SINE_TABLE_BITS_DEF]);
      mag  = quad[0] ? quarter_wave[TBL_N - k] : quarter_wave[k];
      v    = (32'(amp) * 32'(mag)) >> 15;
      if (quad[1]) begin
        v = -v;
      end
      return v[SAMPLE_W-1:0];
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] index,
                          input logic [CFG_DATA_W-1:0] data);
      if (index == CFG_AMPLITUDE) begin
        amp = data[AMP_W-1:0];
      end else if (index == CFG_SAMPLE_RATE) begin
        rate = data[RATE_W-1:0];
      end
    endfunction

    function void note_input(input in_word_t w);
      longint unsigned len;
      out_word_t       r;
      int unsigned     n;
      if (w.command == CMD_NOTE) begin
        len = 64'(w.duration_ms);
        len = (len * 64'(rate)) / 64'(MS_PER_S);
        if (len > LEN_MAX) begin
          len = LEN_MAX;
        end
        r.sample   = '0;
        r.last     = 1'b1;
        r.accepted = 1'b1;
        if (len != 0) begin
          if (queued >= QUEUE_DEPTH_DEF) begin
            r.accepted = 1'b0;
          end else begin
            note_inc[tail]  = w.phase_increment;
            note_left[tail] = len[LEN_W-1:0];
            tail   = (tail + 1) % QUEUE_DEPTH_DEF;
            queued = queued + 1;
          end
        end
        r.queue_count = queued[QCNT_W-1:0];
        expected_words.push_back(r);
      end else begin
        n = 32'(w.sample_count);
        if (n > MAX_BURST_DEF) begin
          n = MAX_BURST_DEF;
        end
        for (int i = 0; i < n; i++) begin
          r.sample = '0;
          if (queued != 0) begin
            r.sample        = tone_value(phase);
            phase           = phase + note_inc[head];
            note_left[head] = note_left[head] - 1'b1;
            if (note_left[head] == 0) begin
              head   = (head + 1) % QUEUE_DEPTH_DEF;
              queued = queued - 1;
            end
          end
          r.last        = (i == n - 1);
          r.accepted    = 1'b0;
          r.queue_count = queued[QCNT_W-1:0];
          expected_words.push_back(r);
        end
      end
    endfunction

    function void check_result(input out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output word: sample %0d last %0b accepted %0b count %0d",
                   $signed(got.sample), got.last, got.accepted, got.queue_count);
        end
        return;
      end
      want = expected_words.pop_front();
      if (got.sample !== want.sample || got.last !== want.last ||
          got.accepted !== want.accepted || got.queue_count !== want.queue_count) begin
        errors++;
        if (errors <= 10) begin
          $display("output mismatch: expected sample %0d last %0b accepted %0b count %0d",
                   $signed(want.sample), want.last, want.accepted, want.queue_count);
          $display("                 got      sample %0d last %0b accepted %0b count %0d",
                   $signed(got.sample), got.last, got.accepted, got.queue_count);
        end
      end
    endfunction

    function int unsigned waiting();
      return expected_words.size();
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_word_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  tone_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int unsigned    stall_left = 0;
  int unsigned    cycles = 0;

  queued_tone_sine_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        sb.note_input(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_index, cfg_data);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_word_t note_word(input logic [INC_W-1:0] inc,
                                         input logic [MS_W-1:0] ms);
    in_word_t w;
    w.command         = CMD_NOTE;
    w.phase_increment = inc;
    w.duration_ms     = ms;
    w.sample_count    = CNT_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t gen_word(input logic [CNT_W-1:0] cnt);
    in_word_t w;
    w.command         = CMD_GEN;
    w.phase_increment = $urandom;
    w.duration_ms     = MS_W'($urandom);
    w.sample_count    = cnt;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every expected word is out and the block has settled
  task automatic program_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] amp_val,
                           input logic [CFG_DATA_W-1:0] rate_val,
                           input bit idle, input int unsigned n);
    int unsigned     ms_cap;
    logic [MS_W-1:0] ms;
    logic [CNT_W-1:0] cnt;
    program_reg(CFG_AMPLITUDE, amp_val);
    program_reg(CFG_SAMPLE_RATE, rate_val);
    idle_on = idle;
    // keep notes short enough that bursts drain them
    ms_cap = (rate_val == 0) ? 65535 : 120000 / rate_val + 1;
    if (ms_cap > 65535) begin
      ms_cap = 65535;
    end
    repeat (n) begin
      if ($urandom_range(0, 99) < 35) begin
        ms = (rate_val == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, ms_cap));
        send_word(note_word($urandom, ms));
      end else begin
        case ($urandom_range(0, 19))
          0:       cnt = '0;
          1:       cnt = CNT_W'($urandom_range(65, 127));
          default: cnt = CNT_W'($urandom_range(1, 64));
        endcase
        send_word(gen_word(cnt));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_word(gen_word(7'd1));
    send_word(gen_word(7'd0));
    send_word(note_word(32'h1234_5678, 16'd0));
    program_reg(CFG_AMPLITUDE, 18'd32767);
    program_reg(CFG_SAMPLE_RATE, 18'd1000);
    send_word(note_word(32'hFFFF_FFFF, 16'd3));
    send_word(note_word(32'h0000_0000, 16'd1));
    send_word(note_word(32'h0010_0000, 16'd64));
    send_word(gen_word(7'd127));
    send_word(gen_word(7'd65));
    repeat (QUEUE_DEPTH_DEF + 1) send_word(note_word($urandom, 16'd1));

    run_phase(18'd32767, 18'd1000, 1'b1, 40);
    run_phase(18'd0, 18'd44100, 1'b1, 40);
    run_phase(CFG_DATA_W'($urandom_range(0, 262143)), 18'd0, 1'b1, 40);
    run_phase(CFG_DATA_W'($urandom_range(0, 32767)), CFG_DATA_W'($urandom_range(1, 3000)),
              1'b0, 40);
    run_phase(18'd1, 18'd192000, 1'b1, 40);
    run_phase(CFG_DATA_W'($urandom_range(0, 262143)),
              CFG_DATA_W'($urandom_range(1000, 192000)), 1'b1, 40);
    run_phase(18'd32767, 18'd8000, 1'b0, 40);

    // saturate the note length, then fill the queue past full
    program_reg(CFG_SAMPLE_RATE, 18'h3FFFF);
    send_word(note_word($urandom, 16'hFFFF));
    send_word(note_word($urandom, 16'hFFFF));
    send_word(gen_word(7'd64));
    send_word(gen_word(7'd64));
    repeat (QUEUE_DEPTH_DEF + 1) send_word(note_word($urandom, 16'd1));
    send_word(gen_word(7'd64));
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/qtsg_pkg.sv
src/qtsg_ram.sv
src/qtsg_sine_rom.sv
src/qtsg_len_div.sv
src/queued_tone_sine_generator.sv
verif/tb.sv
